>>> rtl/ppts_pkg.sv
// Package for the perspective projection unit: field widths, reset values,
// command and register codes, and the control struct of the multiply-accumulate unit.
// No dependencies; every other file imports it.
package ppts_pkg;

   // Default number of fraction bits of all fixed-point values.
   localparam int FRAC_BITS_DEF = 16;

   // Field widths fixed by the interface.
   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int IDX_W     = 4;
   localparam int MAT_DEPTH = 16;
   localparam int DIM_W     = 16;
   localparam int CSR_IDX_W = 1;

   // Reset values of the screen size registers.
   localparam logic [DIM_W-1:0] WIDTH_RST  = 16'd1920;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 16'd1080;

   // Signed 32-bit limits used for saturation.
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // Item commands.
   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_PROJECT = 1'b1
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   // Control of one multiply-accumulate step.
   typedef struct packed {
      logic issue;   // a step enters the unit
      logic first;   // first term of a row: clear the accumulator
      logic last;    // last term of a row: the row sum is complete
      logic word;    // add the matrix word itself instead of a product
   } mac_ctl_type;

endpackage

>>> rtl/ppts_req_if.sv
// Request channel of the perspective projection unit: valid/ready handshake
// carrying a load or project item. Depends on ppts_pkg.
interface ppts_req_if import ppts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [IDX_W-1:0]         elem_index;
   logic signed [WORD_W-1:0] elem_value;
   logic signed [WORD_W-1:0] pos_x;
   logic signed [WORD_W-1:0] pos_y;
   logic signed [WORD_W-1:0] pos_z;

   modport source (output valid, cmd, elem_index, elem_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink   (input valid, cmd, elem_index, elem_value, pos_x, pos_y, pos_z,
                   output ready);
endinterface

>>> rtl/ppts_rsp_if.sv
// Result channel of the perspective projection unit: valid/ready handshake
// carrying the visibility flag and the screen position. Depends on ppts_pkg.
interface ppts_rsp_if import ppts_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     visible;
   logic signed [WORD_W-1:0] screen_x;
   logic signed [WORD_W-1:0] screen_y;

   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

>>> rtl/ppts_mac.sv
// Shared multiply-accumulate unit: a registered 32x32 product stage followed by
// a floor shift and a wide accumulator. Depends on ppts_pkg.
module ppts_mac import ppts_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mac_ctl_type                          ctl,
   input  logic signed [WORD_W-1:0]             coord,
   input  logic signed [WORD_W-1:0]             word,
   output logic                                 res_valid,
   output logic signed [PROD_W+1-FRAC_BITS:0]   acc
);

   localparam int ACC_W = PROD_W + 2 - FRAC_BITS;

   logic signed [PROD_W-1:0] mul_res;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     v1_ff;
   logic                     first1_ff;
   logic                     last1_ff;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     res_valid_ff;

   // The product is exact; a matrix word is pre-shifted so the floor shift returns it unchanged.
   assign mul_res = coord * word;
   assign prod_in = ctl.word ? (PROD_W'(word) <<< FRAC_BITS) : mul_res;

   // Shift right by the fraction bits, rounding toward minus infinity.
   assign term = ACC_W'($signed(prod_ff[PROD_W-1:FRAC_BITS]));

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         first1_ff    <= 1'b0;
         last1_ff     <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= ctl.issue;
         first1_ff    <= ctl.first;
         last1_ff     <= ctl.last;
         res_valid_ff <= v1_ff & last1_ff;
      end
   end

   // Product register and accumulator.
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         prod_ff <= prod_in;
      end
      if (v1_ff) begin
         acc_ff <= (first1_ff ? '0 : acc_ff) + term;
      end
   end

   assign res_valid = res_valid_ff;
   assign acc       = acc_ff;

endmodule

>>> rtl/ppts_div.sv
// Iterative signed fixed-point divider: two restoring quotient bits a cycle,
// truncation toward zero and saturation to 32 bits. Depends on ppts_pkg.
module ppts_div import ppts_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [PROD_W+1-FRAC_BITS:0]   num,
   input  logic signed [PROD_W+1-FRAC_BITS:0]   den,
   output logic                                 done,
   output logic signed [WORD_W-1:0]             quot
);

   localparam int ACC_W    = PROD_W + 2 - FRAC_BITS;
   localparam int DIV_W    = ACC_W + FRAC_BITS;
   localparam int LO_W     = WORD_W;
   localparam int TOP_W    = DIV_W - LO_W;
   localparam int STEPS    = LO_W / 2;
   localparam int CNT_W    = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS - 1);

   typedef enum logic {
      D_IDLE,
      D_RUN
   } div_state_type;

   div_state_type            state_ff;
   logic [ACC_W-1:0]         mag;
   logic [DIV_W-1:0]         dividend;
   logic [TOP_W-1:0]         top;
   logic                     ovf;
   logic [ACC_W-1:0]         rem_ff;
   logic [ACC_W-1:0]         den_ff;
   logic [LO_W-1:0]          lo_ff;
   logic [LO_W-1:0]          q_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     neg_ff;
   logic                     ovf_ff;
   logic                     done_ff;
   logic signed [WORD_W-1:0] quot_ff;
   logic [ACC_W-1:0]         r1;
   logic [ACC_W-1:0]         s1;
   logic [ACC_W-1:0]         r2;
   logic [ACC_W-1:0]         s2;
   logic                     ge1;
   logic                     ge2;
   logic [LO_W-1:0]          q_step;
   logic                     sat;
   logic signed [WORD_W-1:0] quot_res;

   // The dividend is the magnitude scaled by the fraction bits. Its part above the
   // quotient bits must be below the divisor, otherwise the quotient overflows.
   assign mag      = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
   assign dividend = {mag, {FRAC_BITS{1'b0}}};
   assign top      = dividend[DIV_W-1:LO_W];
   assign ovf      = ACC_W'(top) >= ACC_W'(den);

   // Two restoring steps per cycle.
   always_comb begin
      r1     = {rem_ff[ACC_W-2:0], lo_ff[LO_W-1]};
      ge1    = r1 >= den_ff;
      s1     = ge1 ? r1 - den_ff : r1;
      r2     = {s1[ACC_W-2:0], lo_ff[LO_W-2]};
      ge2    = r2 >= den_ff;
      s2     = ge2 ? r2 - den_ff : r2;
      q_step = {q_ff[LO_W-3:0], ge1, ge2};
      sat    = ovf_ff | q_step[LO_W-1];
      if (sat) begin
         quot_res = neg_ff ? WORD_MIN : WORD_MAX;
      end else if (neg_ff) begin
         quot_res = -$signed(q_step);
      end else begin
         quot_res = $signed(q_step);
      end
   end

   // Sequencer with registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  rem_ff   <= ACC_W'(top);
                  lo_ff    <= dividend[LO_W-1:0];
                  den_ff   <= ACC_W'(den);
                  neg_ff   <= num[ACC_W-1];
                  ovf_ff   <= ovf;
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= s2;
               lo_ff  <= {lo_ff[LO_W-3:0], 2'b00};
               q_ff   <= q_step;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CNT) begin
                  quot_ff  <= quot_res;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/perspective_project_to_screen_unit.sv
// Top level of the perspective projection unit: matrix store, size registers,
// sequencer, mapping stage and result register. Depends on ppts_pkg, ppts_req_if,
// ppts_rsp_if, ppts_mac and ppts_div.
//
//   Port group  Direction  Handshake     Carries
//   req_chan    in         valid/ready   cmd, elem_index, elem_value, pos_x/y/z
//   rsp_chan    out        valid/ready   visible, screen_x, screen_y
//   csr_*       in         write enable  screen_width (0), screen_height (1)
//
// A project item runs twelve multiply-adds on the shared MAC; when the point is visible,
// it then takes two divisions on the shared divider and three mapping steps.
// The request side is ready only while the sequencer is idle; a finished result waits
// in the output register, and load items are still taken while it waits.
// Reset is synchronous: it clears the matrix to zero and restores 1920 by 1080.
module perspective_project_to_screen_unit import ppts_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ppts_req_if.sink             req_chan,
   ppts_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int ACC_W  = PROD_W + 2 - FRAC_BITS;
   localparam int TERM_W = WORD_W + 2;
   localparam int MAP_W  = DIM_W + 1 + TERM_W;
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(3 * 4 - 1);
   localparam logic [1:0] SLOT_X = 2'd0;
   localparam logic [1:0] SLOT_Y = 2'd1;
   localparam logic [1:0] SLOT_W = 2'd2;
   localparam logic [1:0] ROW_W_SEL = 2'd3;
   localparam logic signed [ACC_W-1:0] NEAR_W =
      ACC_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic signed [TERM_W-1:0] ONE_Q = TERM_W'(1) <<< FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLIP,
      S_DRAIN,
      S_CHECK,
      S_DIVX,
      S_DIVY,
      S_MAPX,
      S_MAPY,
      S_MAPS
   } state_type;

   state_type                state_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [1:0]               slot_ff;
   logic [WORD_W-1:0]        mat_ff [MAT_DEPTH];
   logic [DIM_W-1:0]         width_ff;
   logic [DIM_W-1:0]         height_ff;
   logic signed [WORD_W-1:0] pos_x_ff;
   logic signed [WORD_W-1:0] pos_y_ff;
   logic signed [WORD_W-1:0] pos_z_ff;
   logic signed [ACC_W-1:0]  cx_ff;
   logic signed [ACC_W-1:0]  cy_ff;
   logic signed [ACC_W-1:0]  cw_ff;
   logic signed [WORD_W-1:0] nx_ff;
   logic signed [WORD_W-1:0] ny_ff;
   logic signed [MAP_W-1:0]  prod_ff;
   logic signed [WORD_W-1:0] sx_stage_ff;
   logic                     rsp_vld_ff;
   logic                     visible_ff;
   logic signed [WORD_W-1:0] screen_x_ff;
   logic signed [WORD_W-1:0] screen_y_ff;

   logic                     accept;
   logic                     out_free;
   logic                     rsp_load;
   logic [1:0]               row_sel;
   logic [IDX_W-1:0]         mat_idx;
   logic signed [WORD_W-1:0] mat_word;
   logic signed [WORD_W-1:0] coord;
   mac_ctl_type              mac_ctl;
   logic                     mac_valid;
   logic signed [ACC_W-1:0]  mac_acc;
   logic                     div_start;
   logic signed [ACC_W-1:0]  div_num;
   logic                     div_done;
   logic signed [WORD_W-1:0] div_quot;
   logic [DIM_W-1:0]         map_dim;
   logic signed [TERM_W-1:0] map_term;
   logic signed [MAP_W-1:0]  map_prod;
   logic signed [WORD_W-1:0] sat_half_res;

   // Halve with floor and saturate to the signed 32-bit range.
   function automatic logic signed [WORD_W-1:0] sat_half(input logic signed [MAP_W-1:0] p);
      logic signed [MAP_W-1:0] h;
      h = p >>> 1;
      if (h > MAP_W'(WORD_MAX)) begin
         return WORD_MAX;
      end else if (h < MAP_W'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return WORD_W'(h);
   endfunction

   // Handshakes.
   assign accept          = req_chan.valid & req_chan.ready;
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign out_free        = ~rsp_vld_ff | rsp_chan.ready;

   // A result enters the output register from the near-plane check or the last mapping step.
   assign rsp_load = out_free &&
                     (((state_ff == S_CHECK) && (cw_ff < NEAR_W)) || (state_ff == S_MAPS));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // Matrix store: sixteen words, cleared at reset, written by load items.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (accept && req_chan.cmd == CMD_LOAD) begin
         mat_ff[req_chan.elem_index] <= req_chan.elem_value;
      end
   end

   // Step counter walks rows x, y and w; within a row three products, then the word.
   assign row_sel  = (step_ff[3:2] == SLOT_W) ? ROW_W_SEL : step_ff[3:2];
   assign mat_idx  = {row_sel, step_ff[1:0]};
   assign mat_word = $signed(mat_ff[mat_idx]);

   always_comb begin
      unique case (step_ff[1:0])
         2'd0:    coord = pos_x_ff;
         2'd1:    coord = pos_y_ff;
         default: coord = pos_z_ff;
      endcase
   end

   assign mac_ctl.issue = (state_ff == S_CLIP);
   assign mac_ctl.first = (step_ff[1:0] == 2'd0);
   assign mac_ctl.last  = (step_ff[1:0] == 2'd3);
   assign mac_ctl.word  = (step_ff[1:0] == 2'd3);

   ppts_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .coord     (coord),
      .word      (mat_word),
      .res_valid (mac_valid),
      .acc       (mac_acc)
   );

   // The divider takes clip x first, then clip y, both over clip w.
   assign div_start = ((state_ff == S_CHECK) && (cw_ff >= NEAR_W)) ||
                      ((state_ff == S_DIVX) && div_done);
   assign div_num   = (state_ff == S_CHECK) ? cx_ff : cy_ff;

   ppts_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (cw_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Screen mapping multiplier: size times (one plus or minus NDC).
   assign map_dim      = (state_ff == S_MAPX) ? width_ff : height_ff;
   assign map_term     = (state_ff == S_MAPX) ? ONE_Q + TERM_W'(nx_ff)
                                              : ONE_Q - TERM_W'(ny_ff);
   assign map_prod     = $signed({1'b0, map_dim}) * map_term;
   assign sat_half_res = sat_half(prod_ff);

   // Sequencer with its datapath and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         step_ff    <= '0;
         slot_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         // The output register fills on a new result and empties when the item is taken.
         rsp_vld_ff <= rsp_load | (rsp_vld_ff & ~rsp_chan.ready);

         // Collect row sums as they leave the accumulator.
         if (mac_valid) begin
            unique case (slot_ff)
               SLOT_X:  cx_ff <= mac_acc;
               SLOT_Y:  cy_ff <= mac_acc;
               default: cw_ff <= mac_acc;
            endcase
            slot_ff <= slot_ff + 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_chan.cmd == CMD_PROJECT) begin
                  pos_x_ff <= req_chan.pos_x;
                  pos_y_ff <= req_chan.pos_y;
                  pos_z_ff <= req_chan.pos_z;
                  step_ff  <= '0;
                  slot_ff  <= '0;
                  state_ff <= S_CLIP;
               end
            end
            S_CLIP: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (mac_valid && slot_ff == SLOT_W) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               // Below the near plane: report an invisible point.
               if (cw_ff < NEAR_W) begin
                  if (out_free) begin
                     visible_ff  <= 1'b0;
                     screen_x_ff <= '0;
                     screen_y_ff <= '0;
                     state_ff    <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_DIVX;
               end
            end
            S_DIVX: begin
               if (div_done) begin
                  nx_ff    <= div_quot;
                  state_ff <= S_DIVY;
               end
            end
            S_DIVY: begin
               if (div_done) begin
                  ny_ff    <= div_quot;
                  state_ff <= S_MAPX;
               end
            end
            S_MAPX: begin
               prod_ff  <= map_prod;
               state_ff <= S_MAPY;
            end
            S_MAPY: begin
               sx_stage_ff <= sat_half_res;
               prod_ff     <= map_prod;
               state_ff    <= S_MAPS;
            end
            S_MAPS: begin
               if (out_free) begin
                  visible_ff  <= 1'b1;
                  screen_x_ff <= sx_stage_ff;
                  screen_y_ff <= sat_half_res;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Result channel.
   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.visible  = visible_ff;
   assign rsp_chan.screen_x = screen_x_ff;
   assign rsp_chan.screen_y = screen_y_ff;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the perspective projection unit: drives load and project
// items, predicts each screen position and compares it with the result channel.
// Depends on ppts_pkg, ppts_req_if, ppts_rsp_if and perspective_project_to_screen_unit.
module testbench;
   import ppts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ONE_Q        = 1 << FRAC_BITS_DEF;
   localparam int     NEAR_W       = (ONE_Q + 5) / 10;
   localparam int     QUIET_LIMIT  = 4000;
   localparam int     SETTLE_CYCLES = 60;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     MAX_REPORTS  = 10;

   typedef struct {
      cmd_type                  cmd;
      logic [IDX_W-1:0]         elem_index;
      logic signed [WORD_W-1:0] elem_value;
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
   } unit_item_type;

   typedef struct {
      logic                     visible;
      logic signed [WORD_W-1:0] screen_x;
      logic signed [WORD_W-1:0] screen_y;
   } screen_pos_type;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   csr_index_type        csr_index = CSR_WIDTH;
   logic [DIM_W-1:0]     csr_wdata = '0;

   // Bus-side copies of the driven values, known from time zero.
   logic           req_valid_q = 1'b0;
   unit_item_type  req_item_q  = '{CMD_LOAD, '0, '0, '0, '0, '0};
   logic           rsp_ready_q = 1'b0;
   logic           req_fire    = 1'b0;

   // Predictor state: matrix store and screen size.
   logic signed [WORD_W-1:0] view_words [MAT_DEPTH];
   logic [DIM_W-1:0]         size_w = WIDTH_RST;
   logic [DIM_W-1:0]         size_h = HEIGHT_RST;

   unit_item_type   pending_items [$];
   screen_pos_type  screen_expect [$];
   screen_pos_type  rsp_want;

   int  items_pushed   = 0;
   int  items_accepted = 0;
   int  loads_taken    = 0;
   int  projects_taken = 0;
   int  visible_seen   = 0;
   int  hidden_seen    = 0;
   int  sizes_used     = 1;
   int  fail_count     = 0;
   int  quiet_cycles   = 0;
   int  send_gap       = 0;
   int  stall_left     = 0;
   int  hold_left      = 0;
   int  hold_requests  = 0;
   int  hold_seen      = 0;
   bit  idle_on        = 1'b1;

   ppts_req_if req_if ();
   ppts_rsp_if rsp_if ();

   assign req_if.valid      = req_valid_q;
   assign req_if.cmd        = req_item_q.cmd;
   assign req_if.elem_index = req_item_q.elem_index;
   assign req_if.elem_value = req_item_q.elem_value;
   assign req_if.pos_x      = req_item_q.pos_x;
   assign req_if.pos_y      = req_item_q.pos_y;
   assign req_if.pos_z      = req_item_q.pos_z;
   assign rsp_if.ready      = rsp_ready_q;

   perspective_project_to_screen_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      foreach (view_words[i]) view_words[i] = '0;
   end

   // Clock: 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [WORD_W-1:0] sat_word(longint v);
      if (v > longint'(WORD_MAX)) return WORD_MAX;
      if (v < longint'(WORD_MIN)) return WORD_MIN;
      return v[WORD_W-1:0];
   endfunction

   // One row of the matrix times (x, y, z, 1); products floored back to Q16.16.
   function automatic longint clip_row(int row, longint x, longint y, longint z);
      return ((x * longint'(view_words[4*row]))     >>> FRAC_BITS_DEF)
           + ((y * longint'(view_words[4*row + 1])) >>> FRAC_BITS_DEF)
           + ((z * longint'(view_words[4*row + 2])) >>> FRAC_BITS_DEF)
           + longint'(view_words[4*row + 3]);
   endfunction

   // Fixed-point quotient, truncated toward zero and saturated to 32 bits.
   function automatic longint ndc_quotient(longint num, longint den);
      logic [127:0] mag;
      logic [127:0] quo;
      mag = (num < 0) ? 128'(-num) : 128'(num);
      quo = (mag << FRAC_BITS_DEF) / 128'(den);
      if (num < 0) begin
         if (quo > 128'h8000_0000) return longint'(WORD_MIN);
         return -longint'(quo[63:0]);
      end
      if (quo > 128'h7FFF_FFFF) return longint'(WORD_MAX);
      return longint'(quo[63:0]);
   endfunction

   function automatic screen_pos_type project_point(longint px, longint py, longint pz);
      screen_pos_type r;
      longint cx, cy, cw, nx, ny;
      cx = clip_row(0, px, py, pz);
      cy = clip_row(1, px, py, pz);
      cw = clip_row(3, px, py, pz);
      if (cw < NEAR_W) begin
         r.visible  = 1'b0;
         r.screen_x = '0;
         r.screen_y = '0;
      end else begin
         nx = ndc_quotient(cx, cw);
         ny = ndc_quotient(cy, cw);
         r.visible  = 1'b1;
         r.screen_x = sat_word((longint'(size_w) * (ONE_Q + nx)) >>> 1);
         r.screen_y = sat_word((longint'(size_h) * (ONE_Q - ny)) >>> 1);
      end
      return r;
   endfunction

   // Update the matrix copy or queue the expected screen position.
   function automatic void apply_item(unit_item_type it);
      if (it.cmd == CMD_LOAD) begin
         view_words[it.elem_index] = it.elem_value;
         loads_taken++;
      end else begin
         screen_expect.push_back(project_point(longint'(it.pos_x), longint'(it.pos_y),
                                               longint'(it.pos_z)));
         projects_taken++;
      end
   endfunction

   function automatic void note_failure(string what, longint want, longint got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("MISMATCH at %0t: %s expected %0d actual %0d", $realtime, what, want, got);
   endfunction

   // ---------------------------------------------------------------- driver

   // Present items at the falling edge; hold each until it has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid_q <= 1'b0;
      end else if (req_valid_q && !req_fire) begin
         req_valid_q <= 1'b1;
      end else if (send_gap > 0) begin
         send_gap    <= send_gap - 1;
         req_valid_q <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         send_gap    <= $urandom_range(0, 2);
         req_valid_q <= 1'b0;
      end else if (pending_items.size() > 0) begin
         req_item_q  <= pending_items.pop_front();
         req_valid_q <= 1'b1;
      end else begin
         req_valid_q <= 1'b0;
      end
   end

   // Record accepted items and feed them to the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            apply_item(req_item_q);
            items_accepted++;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Ready with short random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen   <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready_q <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left   <= hold_left - 1;
         rsp_ready_q <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left  <= stall_left - 1;
         rsp_ready_q <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left  <= $urandom_range(0, 2);
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor

   // Compare each accepted result with the oldest expected screen position.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (screen_expect.size() == 0) begin
            note_failure("result with no project item waiting", 0, longint'(rsp_if.screen_x));
         end else begin
            rsp_want = screen_expect.pop_front();
            if (rsp_want.visible) visible_seen++;
            else hidden_seen++;
            if (rsp_if.visible !== rsp_want.visible)
               note_failure("visible", longint'(rsp_want.visible), longint'(rsp_if.visible));
            if (rsp_if.screen_x !== rsp_want.screen_x)
               note_failure("screen_x", longint'(rsp_want.screen_x),
                            longint'(rsp_if.screen_x));
            if (rsp_if.screen_y !== rsp_want.screen_y)
               note_failure("screen_y", longint'(rsp_want.screen_y),
                            longint'(rsp_if.screen_y));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [WORD_W-1:0] rand_fixed(int unsigned span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - int'(span);
      return v;
   endfunction

   task automatic push_item(unit_item_type it);
      pending_items.push_back(it);
      items_pushed++;
   endtask

   // Load item; the point fields are filled with junk since the block ignores them.
   task automatic push_load(int idx, logic signed [WORD_W-1:0] value);
      push_item('{CMD_LOAD, IDX_W'(idx), value, $urandom(), $urandom(), $urandom()});
   endtask

   // Project item; the load fields carry junk.
   task automatic push_project(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y,
                               logic signed [WORD_W-1:0] z);
      push_item('{CMD_PROJECT, IDX_W'($urandom()), $urandom(), x, y, z});
   endtask

   // Matrix word shaped like a view-projection matrix, now and then raw noise.
   function automatic logic signed [WORD_W-1:0] view_word(int idx);
      int row, col;
      row = idx / 4;
      col = idx % 4;
      if ($urandom_range(0, 15) == 0) return $urandom();
      if (row == 3 && col == 3) return int'($urandom_range(0, 32 * ONE_Q)) - 2 * int'(ONE_Q);
      if (row == 3) return rand_fixed(ONE_Q / 2);
      if (col == 3) return rand_fixed(20 * ONE_Q);
      return rand_fixed(4 * ONE_Q);
   endfunction

   // One random sequence: mostly a matrix load followed by points to project.
   task automatic push_sequence(bit project_heavy);
      int kind, n, i;
      kind = $urandom_range(project_heavy ? 6 : 0, 9);
      if (kind <= 5) begin
         for (i = 0; i < MAT_DEPTH; i++) push_load(i, view_word(i));
         n = $urandom_range(3, 8);
         repeat (n) push_project(rand_fixed(50 * ONE_Q), rand_fixed(50 * ONE_Q),
                                 rand_fixed(50 * ONE_Q));
      end else if (kind <= 7) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0)
               push_load(15, int'(NEAR_W) + rand_fixed(3));
            else
               push_load(int'($urandom_range(0, 15)), view_word($urandom_range(0, 15)));
         end
         n = $urandom_range(2, 5);
         repeat (n) push_project(rand_fixed(50 * ONE_Q), rand_fixed(50 * ONE_Q),
                                 rand_fixed(50 * ONE_Q));
      end else if (kind == 8) begin
         repeat (4) push_item('{cmd_type'($urandom_range(0, 1)), IDX_W'($urandom()),
                                $urandom(), $urandom(), $urandom(), $urandom()});
      end else begin
         n = $urandom_range(2, 5);
         repeat (n) push_project($urandom(), $urandom(), $urandom());
      end
   endtask

   task automatic drain_all();
      while (items_accepted != items_pushed || screen_expect.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      size_w = w;
      size_h = h;
      sizes_used++;
   endtask

   // Reprogram the screen size while idle, then run random sequences.
   task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int count,
                            bit with_hold, bit calm);
      int stop_at;
      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_size(w, h);
      stop_at = items_pushed + count;
      if (with_hold) hold_requests++;
      while (items_pushed < stop_at) begin
         while (pending_items.size() >= 8) @(posedge clock);
         idle_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
         push_sequence(with_hold);
      end
   endtask

   // Directed items under the reset screen size.
   task automatic directed_items();
      // Matrix is all zero after reset, so clip w is zero: not visible.
      push_project(0, 0, 0);
      push_load(0, ONE_Q);
      push_load(5, ONE_Q);
      push_load(15, ONE_Q);
      // Screen centre, then the top-right corner.
      push_project(0, 0, 0);
      push_project(ONE_Q, ONE_Q, 0);
      // Extreme coordinates drive the quotients and the screen values into saturation.
      push_project(WORD_MAX, WORD_MAX, WORD_MAX);
      push_project(WORD_MIN, WORD_MIN, WORD_MIN);
      // Clip w one step below the near threshold, then exactly on it.
      push_load(15, NEAR_W - 1);
      push_project(0, 0, 0);
      push_load(15, NEAR_W);
      push_project(ONE_Q / 20, -(ONE_Q / 20), 0);
      // Extreme matrix words; w grows past 32 bits in the accumulator.
      push_load(3, WORD_MIN);
      push_load(14, WORD_MAX);
      push_project(0, 0, ONE_Q);
      push_project(0, 0, -ONE_Q);
      push_load(12, WORD_MIN);
      push_project(ONE_Q, 0, 0);
      push_project(-ONE_Q, WORD_MAX, 0);
      // A project item with every load field set and a load with point fields set.
      push_item('{CMD_PROJECT, 4'hF, WORD_MIN, 0, 0, 0});
      push_item('{CMD_LOAD, 4'h0, ONE_Q, WORD_MIN, WORD_MAX, -1});
      push_project(-1, -1, -1);
   endtask

   // ---------------------------------------------------------------- sequence of the run

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();
      run_phase(16'd1, 16'd1, 270, 1'b0, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 270, 1'b0, 1'b0);
      run_phase(DIM_W'($urandom_range(1, 65535)), DIM_W'($urandom_range(1, 65535)),
                270, 1'b0, 1'b0);
      // Zero width: the horizontal axis always maps to zero.
      run_phase(16'd0, DIM_W'($urandom_range(1, 65535)), 270, 1'b0, 1'b0);
      run_phase(16'd640, 16'd480, 270, 1'b1, 1'b0);
      run_phase(WIDTH_RST, HEIGHT_RST, 270, 1'b0, 1'b1);

      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      fail_count += screen_expect.size();

      $display("Ran %0d load and %0d project items over %0d screen sizes;",
               loads_taken, projects_taken, sizes_used);
      $display("results: %0d visible, %0d clipped at the near plane, %0d mismatches.",
               visible_seen, hidden_seen, fail_count);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
